[rtl/vtcp_pkg.sv]
package vtcp_pkg;

	localparam int COEFF_WIDTH_DEF  = 16;
	localparam int VERTEX_WIDTH_DEF = 32;
	localparam int COEFF_FRAC       = 12;
	localparam int VIEW_BITS        = 14;
	localparam int CFG_DATA_W       = 64;
	localparam int CFG_INDEX_W      = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ROW0   = 3'd0,
		REG_ROW1   = 3'd1,
		REG_ROW2   = 3'd2,
		REG_ROW3   = 3'd3,
		REG_VIEW_W = 3'd4,
		REG_VIEW_H = 3'd5
	} cfg_reg_t;

	// Outside code bit positions.
	localparam int OC_Z_LO = 0;
	localparam int OC_Z_HI = 1;
	localparam int OC_X_LO = 2;
	localparam int OC_X_HI = 3;
	localparam int OC_Y_LO = 4;
	localparam int OC_Y_HI = 5;

	localparam logic [CFG_DATA_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
	localparam logic [CFG_DATA_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
	localparam logic [CFG_DATA_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;
	localparam logic [VIEW_BITS-1:0]  VIEW_W_RST = 14'd640;
	localparam logic [VIEW_BITS-1:0]  VIEW_H_RST = 14'd480;

endpackage

[rtl/vertex_transform_clip_project.sv]
// Vertex transform, clip outside code and viewport mapping. One vertex may be
// started in every cycle; busy never rises. Each result shows on the output
// ports for one cycle with done high, in request order. The divider takes
// one restoring step per stage for each of the VERTEX_WIDTH+1 quotient bits of
// the three projections, after four stages for the matrix multiply, the clip
// test, the numerators and the division setup. The receiver cannot stall the
// outputs. Matrix and viewport registers should only be written while no
// vertex is in flight.
module vertex_transform_clip_project import vtcp_pkg::*; #(
	parameter int COEFF_WIDTH  = COEFF_WIDTH_DEF,
	parameter int VERTEX_WIDTH = VERTEX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [VERTEX_WIDTH-1:0] vert_x,
	input  logic signed [VERTEX_WIDTH-1:0] vert_y,
	input  logic signed [VERTEX_WIDTH-1:0] vert_z,
	input  logic signed [VERTEX_WIDTH-1:0] vert_w,
	input  logic                           cfg_write,
	input  logic [CFG_INDEX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data,
	output logic                           done,
	output logic signed [VERTEX_WIDTH-1:0] clip_x,
	output logic signed [VERTEX_WIDTH-1:0] clip_y,
	output logic signed [VERTEX_WIDTH-1:0] clip_z,
	output logic signed [VERTEX_WIDTH-1:0] clip_w,
	output logic [5:0]                     outside_code,
	output logic signed [VERTEX_WIDTH-1:0] screen_x,
	output logic signed [VERTEX_WIDTH-1:0] screen_y,
	output logic signed [VERTEX_WIDTH-1:0] depth,
	output logic                           w_zero
);

	localparam int VW   = VERTEX_WIDTH;
	localparam int CW   = COEFF_WIDTH;
	localparam int PW   = CW + VW;
	localparam int SW   = PW + 2;
	localparam int MW   = VW + 16;
	localparam int QB   = VW + 1;
	localparam int NW   = VW + 31;
	localparam int PADW = CFG_DATA_W + 4 * CW;

	typedef struct packed {
		logic [3:0][VW-1:0] clip;
		logic [5:0]         code;
		logic               wz;
	} meta_t;

	typedef struct packed {
		logic          neg;
		logic          ovf;
		logic [VW-1:0] ud;
		logic [QB-1:0] un;
		logic [VW:0]   rem;
		logic [QB-1:0] q;
	} div_t;

	function automatic div_t div_step(input div_t d);
		logic [VW+1:0] t;
		div_t n;
		n = d;
		t = {d.rem, d.un[QB-1]};
		n.un = d.un << 1;
		if (t >= {2'b00, d.ud}) begin
			n.rem = (VW+1)'(t - {2'b00, d.ud});
			n.q = {d.q[QB-2:0], 1'b1};
		end else begin
			n.rem = t[VW:0];
			n.q = {d.q[QB-2:0], 1'b0};
		end
		return n;
	endfunction

	function automatic logic [VW-1:0] sat_sum(input logic signed [SW-1:0] a);
		logic [VW-1:0] r;
		r = a[VW-1:0];
		if (!(&a[SW-1:VW-1]) && (|a[SW-1:VW-1])) begin
			r = a[SW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
		end
		return r;
	endfunction

	// Configuration registers.
	logic [CFG_DATA_W-1:0] row_q [4];
	logic [VIEW_BITS-1:0]  view_w_q;
	logic [VIEW_BITS-1:0]  view_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW0_RST;
			row_q[1] <= ROW1_RST;
			row_q[2] <= ROW2_RST;
			row_q[3] <= ROW3_RST;
			view_w_q <= VIEW_W_RST;
			view_h_q <= VIEW_H_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ROW0:   row_q[0] <= cfg_data;
				REG_ROW1:   row_q[1] <= cfg_data;
				REG_ROW2:   row_q[2] <= cfg_data;
				REG_ROW3:   row_q[3] <= cfg_data;
				REG_VIEW_W: view_w_q <= cfg_data[VIEW_BITS-1:0];
				REG_VIEW_H: view_h_q <= cfg_data[VIEW_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Valid bits.
	logic vld_s1, vld_s2, vld_s3;
	logic vld_sdiv [QB+1];
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int k = 0; k <= QB; k++) vld_sdiv[k] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_sdiv[0] <= vld_s3;
			for (int k = 0; k < QB; k++) vld_sdiv[k+1] <= vld_sdiv[k];
			done_q <= vld_sdiv[QB];
		end
	end

	assign busy = 1'b0;
	assign done = done_q;

	// Stage 1: sixteen products.
	logic signed [VW-1:0]   vin [4];
	logic signed [CW-1:0]   coef [4][4];
	logic [PADW-1:0]        row_pad [4];
	logic signed [PW-1:0]   prod_s1 [4][4];

	assign vin[0] = vert_x;
	assign vin[1] = vert_y;
	assign vin[2] = vert_z;
	assign vin[3] = vert_w;

	// Lanes that fall past the 64-bit row read as zero.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			row_pad[i] = {{(4*CW){1'b0}}, row_q[i]};
			for (int j = 0; j < 4; j++) begin
				coef[i][j] = row_pad[i][j*CW +: CW];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				prod_s1[i][j] <= coef[i][j] * vin[i];
			end
		end
	end

	// Stage 2: column sums, rounding and saturation.
	logic signed [SW-1:0] acc [4];
	logic signed [SW-1:0] shf [4];
	logic signed [VW-1:0] c_s2 [4];

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			acc[j] = SW'(prod_s1[0][j]) + SW'(prod_s1[1][j]) + SW'(prod_s1[2][j])
				+ SW'(prod_s1[3][j]) + (SW'(1) <<< (COEFF_FRAC - 1));
			shf[j] = acc[j] >>> COEFF_FRAC;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 4; j++) c_s2[j] <= sat_sum(shf[j]);
	end

	// Stage 3: outside code and the scaled screen numerators.
	logic signed [VW:0]   xpw, wmy, negw, cx, cy, cz, cw;
	logic signed [MW-1:0] num_s3 [2];
	meta_t                meta_s3;

	always_comb begin
		cx = (VW+1)'(c_s2[0]);
		cy = (VW+1)'(c_s2[1]);
		cz = (VW+1)'(c_s2[2]);
		cw = (VW+1)'(c_s2[3]);
		xpw = cx + cw;
		wmy = cw - cy;
		negw = -cw;
	end

	always_ff @(posedge clk) begin
		num_s3[0] <= xpw * $signed({1'b0, view_w_q});
		num_s3[1] <= wmy * $signed({1'b0, view_h_q});
		for (int j = 0; j < 4; j++) meta_s3.clip[j] <= c_s2[j];
		meta_s3.code[OC_Z_LO] <= cz < negw;
		meta_s3.code[OC_Z_HI] <= cz > cw;
		meta_s3.code[OC_X_LO] <= cx < negw;
		meta_s3.code[OC_X_HI] <= cx > cw;
		meta_s3.code[OC_Y_LO] <= cy < negw;
		meta_s3.code[OC_Y_HI] <= cy > cw;
		meta_s3.wz <= (c_s2[3] == '0);
	end

	// Stage 4: magnitudes, signs and quotient overflow check, then one
	// restoring step per stage for the three divisions (x, y, depth).
	logic signed [NW-1:0] nl [3];
	logic [NW-1:0]        un_full [3];
	logic [NW-1:0]        up [3];
	logic [VW-1:0]        ud;
	logic                 dneg;
	div_t                 dinit [3];
	div_t                 dv_sdiv [QB+1][3];
	meta_t                meta_sdiv [QB+1];

	always_comb begin
		dneg = meta_s3.clip[3][VW-1];
		ud = dneg ? VW'(-$signed(meta_s3.clip[3])) : meta_s3.clip[3];
		nl[0] = NW'(num_s3[0]) <<< 15;
		nl[1] = NW'(num_s3[1]) <<< 15;
		nl[2] = NW'($signed(meta_s3.clip[2])) <<< 16;
		for (int l = 0; l < 3; l++) begin
			un_full[l] = nl[l][NW-1] ? NW'(-nl[l]) : nl[l];
			up[l] = un_full[l] >> QB;
			dinit[l].neg = nl[l][NW-1] ^ dneg;
			dinit[l].ovf = up[l] >= NW'(ud);
			dinit[l].ud = ud;
			dinit[l].un = un_full[l][QB-1:0];
			dinit[l].rem = up[l][VW:0];
			dinit[l].q = '0;
		end
	end

	always_ff @(posedge clk) begin
		meta_sdiv[0] <= meta_s3;
		for (int l = 0; l < 3; l++) dv_sdiv[0][l] <= dinit[l];
		for (int k = 0; k < QB; k++) begin
			meta_sdiv[k+1] <= meta_sdiv[k];
			for (int l = 0; l < 3; l++) dv_sdiv[k+1][l] <= div_step(dv_sdiv[k][l]);
		end
	end

	// Last stage: zero when w is zero, else round half away from zero, apply sign, saturate.
	localparam logic [QB:0] LIM_POS = ((QB+1)'(1) << (VW - 1)) - (QB+1)'(1);
	localparam logic [QB:0] LIM_NEG = (QB+1)'(1) << (VW - 1);

	logic          rnd [3];
	logic [QB:0]   qq [3];
	logic [VW-1:0] res [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			rnd[l] = {dv_sdiv[QB][l].rem, 1'b0} >= {2'b00, dv_sdiv[QB][l].ud};
			qq[l] = (QB+1)'(dv_sdiv[QB][l].q) + (QB+1)'(rnd[l]);
			if (meta_sdiv[QB].wz) begin
				res[l] = '0;
			end else if (dv_sdiv[QB][l].neg) begin
				if (dv_sdiv[QB][l].ovf || qq[l] > LIM_NEG)
					res[l] = {1'b1, {(VW-1){1'b0}}};
				else
					res[l] = VW'((QB+1)'(0) - qq[l]);
			end else begin
				if (dv_sdiv[QB][l].ovf || qq[l] > LIM_POS)
					res[l] = {1'b0, {(VW-1){1'b1}}};
				else
					res[l] = qq[l][VW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		clip_x <= meta_sdiv[QB].clip[0];
		clip_y <= meta_sdiv[QB].clip[1];
		clip_z <= meta_sdiv[QB].clip[2];
		clip_w <= meta_sdiv[QB].clip[3];
		outside_code <= meta_sdiv[QB].code;
		w_zero <= meta_sdiv[QB].wz;
		screen_x <= res[0];
		screen_y <= res[1];
		depth <= res[2];
	end

endmodule

[test/tb_vertex_transform_clip_project.sv]
`timescale 1ns / 100ps

module tb_vertex_transform_clip_project;
	import vtcp_pkg::*;

	localparam int VW = VERTEX_WIDTH_DEF;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE6 = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE7 = 3'd7;
	localparam int LATENCY_WAIT = 45;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic signed [VW-1:0] cx, cy, cz, cw;
		logic [5:0]           code;
		logic signed [VW-1:0] sx, sy, dz;
		logic                 wz;
	} vertex_result_t;

	class projection_scoreboard;
		logic [CFG_DATA_W-1:0] rows[4];
		logic [VIEW_BITS-1:0]  view_w, view_h;
		vertex_result_t        pending[$];
		int                    mismatches;

		function new();
			rows[0] = ROW0_RST;
			rows[1] = ROW1_RST;
			rows[2] = ROW2_RST;
			rows[3] = ROW3_RST;
			view_w = VIEW_W_RST;
			view_h = VIEW_H_RST;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (cfg_reg_t'(idx))
				REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: rows[idx] = d;
				REG_VIEW_W: view_w = d[VIEW_BITS-1:0];
				REG_VIEW_H: view_h = d[VIEW_BITS-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		// Quotient rounded to nearest with ties away from zero.
		function longint divide_round(longint num, longint den);
			bit neg;
			longint unsigned un, ud, q, r;
			neg = (num < 0) != (den < 0);
			un = (num < 0) ? -num : num;
			ud = (den < 0) ? -den : den;
			q = un / ud;
			r = un % ud;
			if (r >= ud - r) q++;
			if (q > (64'd1 << 40)) q = 64'd1 << 40;
			return clamp32(neg ? -longint'(q) : longint'(q));
		endfunction

		function void note_vertex(logic signed [VW-1:0] vx, vy, vz, vw);
			longint v[4], c[4], acc, cf;
			vertex_result_t e;
			v[0] = longint'(vx); v[1] = longint'(vy);
			v[2] = longint'(vz); v[3] = longint'(vw);
			for (int j = 0; j < 4; j++) begin
				acc = 0;
				for (int i = 0; i < 4; i++) begin
					cf = longint'($signed(rows[i][16*j +: 16]));
					acc += cf * v[i];
				end
				acc += 64'sd1 << (COEFF_FRAC - 1);
				c[j] = clamp32(acc >>> COEFF_FRAC);
			end
			e.cx = VW'(c[0]); e.cy = VW'(c[1]); e.cz = VW'(c[2]); e.cw = VW'(c[3]);
			e.code = '0;
			e.code[OC_Z_LO] = c[2] < -c[3];
			e.code[OC_Z_HI] = c[2] > c[3];
			e.code[OC_X_LO] = c[0] < -c[3];
			e.code[OC_X_HI] = c[0] > c[3];
			e.code[OC_Y_LO] = c[1] < -c[3];
			e.code[OC_Y_HI] = c[1] > c[3];
			e.wz = (c[3] == 0);
			e.sx = '0; e.sy = '0; e.dz = '0;
			if (!e.wz) begin
				e.sx = VW'(divide_round((c[0] + c[3]) * longint'(view_w) * 32768, c[3]));
				e.sy = VW'(divide_round((c[3] - c[1]) * longint'(view_h) * 32768, c[3]));
				e.dz = VW'(divide_round(c[2] * 65536, c[3]));
			end
			pending.push_back(e);
		endfunction

		function void check_result(vertex_result_t got);
			vertex_result_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no request outstanding", $realtime);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch exp clip %h %h %h %h code %h scr %h %h %h wz %b",
						$realtime, e.cx, e.cy, e.cz, e.cw, e.code, e.sx, e.sy, e.dz, e.wz,
						" got clip %h %h %h %h code %h scr %h %h %h wz %b",
						got.cx, got.cy, got.cz, got.cw, got.code, got.sx, got.sy,
						got.dz, got.wz);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic signed [VW-1:0] vert_x = 0, vert_y = 0, vert_z = 0, vert_w = 0;
	logic cfg_write = 0;
	logic [CFG_INDEX_W-1:0] cfg_index = 0;
	logic [CFG_DATA_W-1:0] cfg_data = 0;
	logic busy, done, w_zero;
	logic signed [VW-1:0] clip_x, clip_y, clip_z, clip_w, screen_x, screen_y, depth;
	logic [5:0] outside_code;

	projection_scoreboard sb = new();
	int idle_pct;
	int quiet_cycles;

	vertex_transform_clip_project dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		vertex_result_t got;
		if (arst_n) begin
			if (cfg_write) sb.write_reg(cfg_index, cfg_data);
			if (start && !busy) sb.note_vertex(vert_x, vert_y, vert_z, vert_w);
			if (done) begin
				got = '{clip_x, clip_y, clip_z, clip_w, outside_code,
					screen_x, screen_y, depth, w_zero};
				sb.check_result(got);
			end
			quiet_cycles = ((start && !busy) || done) ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("vertex_transform_clip_project test failed");
				$finish;
			end
		end
	end

	// Holds the request until the block takes it; busy is tied low by the block and sampled at the falling edge.
	task automatic send_vertex(logic signed [VW-1:0] x, y, z, w);
		while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		vert_x <= x; vert_y <= y; vert_z <= z; vert_w <= w;
		start <= 1;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_write <= 0;
	endtask

	function automatic logic [15:0] rand_coeff();
		if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 16'hffff));
		return 16'($signed($urandom_range(0, 16384)) - 8192);
	endfunction

	task automatic random_matrix();
		for (int i = 0; i < 4; i++)
			write_reg(i[CFG_INDEX_W-1:0], {rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff()});
	endtask

	task automatic random_vertex();
		logic signed [VW-1:0] p[4];
		int mode;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 4; i++) begin
			if (mode < 2) p[i] = $urandom();
			else p[i] = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
		end
		if (mode == 2) p[3] = 0;
		else if (mode > 2) begin
			p[3] = $urandom_range(1 << 14, 8 << 16);
			if ($urandom_range(0, 3) == 0) p[3] = -p[3];
		end
		send_vertex(p[0], p[1], p[2], p[3]);
	endtask

	initial begin
		quiet_cycles = 0;
		idle_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Identity matrix with the reset viewport.
		send_vertex(0, 0, 0, 0);
		send_vertex(0, 0, 0, 32'sh10000);
		send_vertex(32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000);
		send_vertex(-32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000);
		send_vertex(32'sh20000, 0, 0, 32'sh10000);
		send_vertex(-32'sh20000, 0, 0, 32'sh10000);
		send_vertex(0, 32'sh20000, 0, 32'sh10000);
		send_vertex(0, -32'sh20000, 0, 32'sh10000);
		send_vertex(0, 0, 32'sh20000, 32'sh10000);
		send_vertex(0, 0, -32'sh20000, 32'sh10000);
		send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1);
		send_vertex(32'sh10000, -32'sh10000, 32'sh8000, 0);
		send_vertex(32'sh8000, 32'sh8000, 32'sh8000, -32'sh10000);
		send_vertex(1, -1, 1, 3);
		drain();

		// Extreme coefficients saturate every clip lane of the first vertex below.
		write_reg(REG_ROW0, 64'h7fff_7fff_7fff_7fff);
		write_reg(REG_ROW1, 64'h8000_8000_8000_8000);
		write_reg(REG_ROW2, 64'h7fff_8000_7fff_8000);
		write_reg(REG_ROW3, 64'h8000_7fff_8000_7fff);
		write_reg(REG_VIEW_W, 64'd16383);
		write_reg(REG_VIEW_H, 64'd0);
		write_reg(REG_SPARE6, 64'hffff_ffff_ffff_ffff);
		write_reg(REG_SPARE7, 64'h0);
		send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
		send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_vertex(32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000);
		send_vertex(0, 0, 0, 0);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 16 : (phase == 1) ? 55 : 0;
			for (int k = 0; k < 3; k++) begin
				case (k)
					0: begin
						write_reg(REG_ROW0, ROW0_RST);
						write_reg(REG_ROW1, ROW1_RST);
						write_reg(REG_ROW2, ROW2_RST);
						write_reg(REG_ROW3, ROW3_RST);
						write_reg(REG_VIEW_W, phase == 0 ? 64'd8192 : 64'd1);
						write_reg(REG_VIEW_H, phase == 1 ? 64'd8192 : 64'd16383);
					end
					default: begin
						random_matrix();
						write_reg(REG_VIEW_W, 64'($urandom_range(0, 16383)));
						write_reg(REG_VIEW_H, 64'($urandom_range(0, 16383)));
					end
				endcase
				repeat (70) random_vertex();
				drain();
			end
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("vertex_transform_clip_project test passed");
		end else begin
			$display("vertex_transform_clip_project test failed");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/vtcp_pkg.sv
rtl/vertex_transform_clip_project.sv
test/tb_vertex_transform_clip_project.sv
